[src/bmhq_pkg.sv]
package bmhq_pkg;

    localparam int KEY_W    = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 9;
    localparam int IN_DW    = 32;
    localparam int OUT_DW   = 48;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_PEEK    = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD,
        S_EX_LD,
        S_DN_RD,
        S_DN_CH,
        S_DN_MV,
        S_PK_RD,
        S_PK_LD,
        S_FIN
    } t_state;

endpackage

[src/binary_max_heap_queue.sv]
// Channel   Dir  tdata                              tuser
// s_axis    in   [31:0] key_in (low 32 of 32)       [1:0] action
// m_axis    out  [31:0] key_out, [40:32] occupancy  [1:0] status
//
// Per item: insert climbs the new key from the tail, at most log2 CAPACITY
// levels; extract returns the root and, unless the heap empties, sinks the
// tail key until it reaches a leaf or settles above its children; peek reads
// the root; empty, full and unused actions go straight to the result.
// One memory write port, two registered read ports and one shared signed
// comparator make up the datapath. Reset is synchronous and empties the heap at
// once (no clearing pass). A result waits in the output register while the
// next item is taken; the sequencer stalls in its final state only when the
// previous result has not been taken yet.
module binary_max_heap_queue #(
    parameter int CAPACITY = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bmhq_pkg::IN_DW-1:0]    s_axis_tdata,  // [31:0] key_in
    input  logic [bmhq_pkg::ACT_W-1:0]    s_axis_tuser,  // [1:0] action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [bmhq_pkg::OUT_DW-1:0]   m_axis_tdata,  // [31:0] key_out, [40:32] occupancy
    output logic [bmhq_pkg::STAT_W-1:0]   m_axis_tuser   // [1:0] status
);
    import bmhq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_pos, n_pos;
    t_key            r_key, n_key;
    t_key            r_best_val, n_best_val;
    logic [CW-1:0]   r_best_pos, n_best_pos;
    logic            r_has_r, n_has_r;
    t_key            r_res_key, n_res_key;
    t_status         r_res_status, n_res_status;
    logic            r_out_valid, n_out_valid;
    t_key            r_out_key;
    t_status         r_out_status;
    logic [OCC_W-1:0] r_out_occ;

    t_key            r_heap [CAPACITY];
    t_key            r_rd0, r_rd1;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr, rd_addr0, rd_addr1;
    t_key            mem_wdata;

    t_key            cmp_a, cmp_b;
    logic            cmp_gt;

    logic            in_xfer, out_free;
    t_action         in_act;
    logic [CW:0]     child_l, child_r;
    logic            dn_leaf;
    logic [CW-1:0]   parent;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign in_act   = t_action'(s_axis_tuser);
    assign out_free = !r_out_valid || m_axis_tready;
    assign child_l  = {r_pos, 1'b0};
    assign child_r  = child_l + (CW+1)'(1);
    assign dn_leaf  = child_l > {1'b0, r_cnt};
    assign parent   = r_pos >> 1;

    // shared signed comparator
    assign cmp_gt = cmp_a > cmp_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (in_act)
                        ACT_INSERT:  n_state = (r_cnt >= CAP_CNT) ? S_FIN : S_UP_RD;
                        ACT_EXTRACT: n_state = (r_cnt == '0) ? S_FIN : S_EX_RD;
                        ACT_PEEK:    n_state = (r_cnt == '0) ? S_FIN : S_PK_RD;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_UP_RD:  n_state = (r_pos == CW'(1)) ? S_FIN : S_UP_CMP;
            S_UP_CMP: n_state = cmp_gt ? S_UP_RD : S_FIN;
            S_EX_RD:  n_state = S_EX_LD;
            S_EX_LD:  n_state = (r_cnt == '0) ? S_FIN : S_DN_RD;
            S_DN_RD:  n_state = dn_leaf ? S_FIN : S_DN_CH;
            S_DN_CH:  n_state = S_DN_MV;
            S_DN_MV:  n_state = cmp_gt ? S_DN_RD : S_FIN;
            S_PK_RD:  n_state = S_PK_LD;
            S_PK_LD:  n_state = S_FIN;
            S_FIN:    n_state = out_free ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_key        = r_key;
        n_best_val   = r_best_val;
        n_best_pos   = r_best_pos;
        n_has_r      = r_has_r;
        n_res_key    = r_res_key;
        n_res_status = r_res_status;
        mem_we       = 1'b0;
        mem_waddr    = IW'(r_pos - CW'(1));
        mem_wdata    = r_key;
        rd_addr0     = '0;
        rd_addr1     = '0;
        cmp_a        = r_key;
        cmp_b        = r_rd0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_key    = '0;
                    n_res_status = STAT_OK;
                    case (in_act)
                        ACT_INSERT: begin
                            if (r_cnt >= CAP_CNT) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                n_cnt = r_cnt + CW'(1);
                                n_pos = r_cnt + CW'(1);
                                n_key = t_key'(s_axis_tdata[KEY_W-1:0]);
                            end
                        end
                        ACT_EXTRACT: begin
                            if (r_cnt == '0) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                            end
                        end
                        ACT_PEEK: begin
                            if (r_cnt == '0) begin
                                n_res_status = STAT_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UP_RD: begin
                rd_addr0 = IW'(parent - CW'(1));
                if (r_pos == CW'(1)) begin
                    mem_we = 1'b1;
                end
            end
            S_UP_CMP: begin
                // parent moves down into the hole, or the key settles here
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = r_rd0;
                    n_pos     = parent;
                end
            end
            S_EX_RD: begin
                rd_addr0 = '0;
                rd_addr1 = IW'(r_cnt);
            end
            S_EX_LD: begin
                n_res_key = r_rd0;
                n_key     = r_rd1;
                n_pos     = CW'(1);
            end
            S_DN_RD: begin
                rd_addr0 = IW'(child_l - (CW+1)'(1));
                rd_addr1 = IW'(child_l);
                n_has_r  = child_r <= {1'b0, r_cnt};
                if (dn_leaf) begin
                    mem_we = 1'b1;
                end
            end
            S_DN_CH: begin
                // right child wins only when strictly greater
                cmp_a = r_rd1;
                cmp_b = r_rd0;
                if (r_has_r && cmp_gt) begin
                    n_best_val = r_rd1;
                    n_best_pos = CW'({r_pos, 1'b1});
                end else begin
                    n_best_val = r_rd0;
                    n_best_pos = CW'({r_pos, 1'b0});
                end
            end
            S_DN_MV: begin
                cmp_a  = r_best_val;
                cmp_b  = r_key;
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = r_best_val;
                    n_pos     = r_best_pos;
                end
            end
            S_PK_RD: rd_addr0 = '0;
            S_PK_LD: n_res_key = r_rd0;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        if (r_state == S_FIN && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_heap[mem_waddr] <= mem_wdata;
        end
        r_rd0 <= r_heap[rd_addr0];
        r_rd1 <= r_heap[rd_addr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_best_val   <= n_best_val;
        r_best_pos   <= n_best_pos;
        r_has_r      <= n_has_r;
        r_res_key    <= n_res_key;
        r_res_status <= n_res_status;
        if (r_state == S_FIN && out_free) begin
            r_out_key    <= r_res_key;
            r_out_status <= r_res_status;
            r_out_occ    <= OCC_W'(r_cnt);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DW - KEY_W - OCC_W)'(0), r_out_occ, r_out_key};
    assign m_axis_tuser  = r_out_status;

endmodule

[src/bmhq_checker.sv]
module bmhq_checker #(
    parameter int CAPACITY = 256
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser
);
    import bmhq_pkg::*;

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: the sequencer is busy right after a transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_EMPTY |->
            m_axis_tdata[31:0] == '0 && m_axis_tdata[40:32] == '0)
        else $error("empty status with nonzero key or occupancy");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_FULL |->
            m_axis_tdata[31:0] == '0 && m_axis_tdata[40:32] == FULL_OCC)
        else $error("full status with wrong key or occupancy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind binary_max_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int HEAP_DEPTH  = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // Code 3 is not decoded by the block: expect a no-op.
    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    localparam t_key KEY_MAX = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN = 32'sh8000_0000;

    typedef struct {
        t_key             key_out;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_heap_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DW-1:0]     s_axis_tdata  = '0;   // [31:0] key_in
    logic [ACT_W-1:0]     s_axis_tuser  = '0;   // [1:0] action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]    m_axis_tdata;         // [31:0] key_out, [40:32] occupancy
    logic [STAT_W-1:0]    m_axis_tuser;         // [1:0] status

    // Predicted heap, slots 1..heap_count in use.
    t_key         heap_keys [1:HEAP_DEPTH];
    int           heap_count = 0;
    t_heap_result pending_results [$];

    int err_count     = 0;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int sink_hold_req = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    binary_max_heap_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_heap_result heap_apply(input logic [ACT_W-1:0] act, input t_key key);
        t_heap_result r;
        int           n;
        int           l;
        int           best;
        t_key         tmp;
        r.key_out = '0;
        r.status  = STAT_OK;
        case (act)
            ACT_INSERT: begin
                if (heap_count >= HEAP_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    heap_count++;
                    heap_keys[heap_count] = key;
                    n = heap_count;
                    // climb while strictly greater than the parent
                    while (n > 1 && heap_keys[n] > heap_keys[n / 2]) begin
                        tmp               = heap_keys[n];
                        heap_keys[n]      = heap_keys[n / 2];
                        heap_keys[n / 2]  = tmp;
                        n                 = n / 2;
                    end
                end
            end
            ACT_EXTRACT: begin
                if (heap_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.key_out    = heap_keys[1];
                    heap_keys[1] = heap_keys[heap_count];
                    heap_count--;
                    n = 1;
                    while (2 * n <= heap_count) begin
                        l    = 2 * n;
                        best = l;
                        // left child wins a tie between the children
                        if (l + 1 <= heap_count && heap_keys[l + 1] > heap_keys[l])
                            best = l + 1;
                        if (!(heap_keys[best] > heap_keys[n]))
                            break;
                        tmp             = heap_keys[n];
                        heap_keys[n]    = heap_keys[best];
                        heap_keys[best] = tmp;
                        n               = best;
                    end
                end
            end
            ACT_PEEK: begin
                if (heap_count == 0)
                    r.status = STAT_EMPTY;
                else
                    r.key_out = heap_keys[1];
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(heap_count);
        return r;
    endfunction

    function automatic t_key rand_key();
        case ($urandom_range(3))
            0: return t_key'(int'($urandom_range(16)) - 8);
            1: begin
                case ($urandom_range(3))
                    0: return KEY_MAX;
                    1: return KEY_MIN;
                    2: return '0;
                    default: return t_key'(-1);
                endcase
            end
            default: return t_key'($urandom);
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] rand_action();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return ACT_INSERT;
        else if (r < 78)
            return ACT_EXTRACT;
        else if (r < 93)
            return ACT_PEEK;
        else
            return ACT_NOP;
    endfunction

    // Returns at the rising edge of the transfer; tvalid stays up until the next falling edge.
    task automatic send_item(input logic [ACT_W-1:0] act, input t_key key);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= ACT_W'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= act;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_results = {pending_results, heap_apply(act, key)};
    endtask

    task automatic finish_outstanding();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_item(ACT_PEEK, '0);
        send_item(ACT_EXTRACT, t_key'(-1));
        send_item(ACT_NOP, KEY_MAX);
        send_item(ACT_INSERT, '0);
        send_item(ACT_INSERT, KEY_MAX);
        send_item(ACT_INSERT, KEY_MIN);
        send_item(ACT_INSERT, t_key'(-1));
        send_item(ACT_INSERT, 32'shAAAA_AAAA);
        send_item(ACT_INSERT, 32'sh5555_5555);
        // equal keys exercise the tie rules in both sift directions
        send_item(ACT_INSERT, 5);
        send_item(ACT_INSERT, 5);
        send_item(ACT_INSERT, 5);
        send_item(ACT_PEEK, t_key'($urandom));
        send_item(ACT_NOP, t_key'($urandom));
        repeat (10)
            send_item(ACT_EXTRACT, t_key'($urandom));
        finish_outstanding();
    endtask

    task automatic test_full_heap();
        repeat (HEAP_DEPTH)
            send_item(ACT_INSERT, rand_key());
        send_item(ACT_INSERT, KEY_MAX);
        send_item(ACT_INSERT, rand_key());
        send_item(ACT_NOP, rand_key());
        send_item(ACT_PEEK, rand_key());
        send_item(ACT_INSERT, KEY_MIN);
        repeat (HEAP_DEPTH + 1)
            send_item(ACT_EXTRACT, rand_key());
        finish_outstanding();
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_item(rand_action(), rand_key());
        finish_outstanding();
    endtask

    // Hold the output off so the block fills and backs up its input.
    task automatic test_output_stall();
        sink_hold_req = HOLD_CYCLES;
        repeat (30)
            send_item(rand_action(), rand_key());
        finish_outstanding();
    endtask

    always @(negedge i_clk) begin
        if (sink_hold_req != 0) begin
            hold_left     = sink_hold_req;
            sink_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_heap_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: key_out %0d, status %0d, occupancy %0d",
                       $signed(m_axis_tdata[KEY_W-1:0]), m_axis_tuser,
                       m_axis_tdata[KEY_W+OCC_W-1:KEY_W]);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[KEY_W-1:0] !== want.key_out) begin
                    $error("key_out: expected %0d, got %0d", want.key_out,
                           $signed(m_axis_tdata[KEY_W-1:0]));
                    err_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[KEY_W+OCC_W-1:KEY_W] !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           m_axis_tdata[KEY_W+OCC_W-1:KEY_W]);
                    err_count++;
                end
            end
        end
    end

    // Count cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 34;
        snk_idle_pct = 69;
        test_directed_cases();
        test_full_heap();
        test_random_mix(250);

        src_idle_pct = 69;
        snk_idle_pct = 34;
        test_random_mix(250);
        test_output_stall();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_mix(250);

        // let any stray result surface
        repeat (40)
            @(posedge i_clk);
        if (err_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
